[sv/ultrasonic_echo_ranger_assert.svh]
// assertion macros used by the echo ranger queue
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

`ifndef SYNTHESIS
`define UER_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("uer assertion failed");
`define UER_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("uer forbidden condition seen");
`else
`define UER_ASSERT(lbl, clk, rst_n, prop)
`define UER_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[sv/uer_pkg.sv]
// shared types and constants of the ultrasonic echo ranger
package uer_pkg;

	localparam int TRIG_W    = 8;
	localparam int TICK_W    = 20;
	localparam int RDG_W     = 4;
	localparam int TPC_W     = 8;
	localparam int DEN_W     = 11;
	localparam int DIST_W    = 19;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 20;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	localparam logic [RDG_W-1:0] RDG_MAX = RDG_W'(8);

	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READINGS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TPC      = 2'd3;

	localparam logic [TRIG_W-1:0] RST_TRIGGER  = 8'd20;
	localparam logic [TICK_W-1:0] RST_SETTLE   = 20'd50000;
	localparam logic [RDG_W-1:0]  RST_READINGS = 4'd5;
	localparam logic [TPC_W-1:0]  RST_TPC      = 8'd58;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_TRIG   = 3'd1,
		PH_WAIT   = 3'd2,
		PH_MEAS   = 3'd3,
		PH_SETTLE = 3'd4
	} ph_t;

	typedef enum logic [1:0] {
		BK_LOAD = 2'd0,
		BK_DIV  = 2'd1,
		BK_DONE = 2'd2
	} bk_t;

	typedef struct packed {
		logic trig;
		logic busy;
		logic res;
	} ctl_t;

	localparam int CTL_W = $bits(ctl_t);

endpackage

[sv/ultrasonic_echo_ranger.sv]
// top level of the ultrasonic echo ranger: config registers, front, queue, back
//
//  channel  direction  payload
//  s_*      in         tdata[0] start_req, tdata[1] echo_level
//  m_*      out        tdata[0] trigger_level, [1] busy_res, [2] result_valid,
//                      [21:3] distance_q8
//  cfg_*    in         write of register cfg_index with cfg_data
//
// an ordinary tick item goes through the queue into the output register and is offered
// on m_* from there; the item that gives a distance stays in the back end while the
// one-bit-per-cycle restoring divider works; the two-entry queue takes up to two more
// ticks meanwhile, then s_tready stays low until the output register takes the distance
// asynchronous reset clears sequencer, queue and output valid; no clearing pass
// s_tready falls only while the queue is full; m_tvalid holds until taken
module ultrasonic_echo_ranger #(
	parameter int WIDTH_BITS    = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [uer_pkg::IN_DATA_W-1:0]     s_tdata,  // start_req, echo_level
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// trigger_level, busy_res, result_valid, distance_q8
	output logic [uer_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [uer_pkg::CFG_W-1:0]         cfg_data
);
	import uer_pkg::*;

	localparam int SUM_W = WIDTH_BITS + 3;
	localparam int ENT_W = CTL_W + DEN_W + SUM_W;

	logic [TRIG_W-1:0] trigger_q;
	logic [TICK_W-1:0] settle_q;
	logic [RDG_W-1:0]  readings_q;
	logic [TPC_W-1:0]  tpc_q;

	logic              take, full, empty, pop;
	ctl_t              f_ctl, b_ctl;
	logic [SUM_W-1:0]  f_sum, b_sum;
	logic [DEN_W-1:0]  f_den, b_den;
	logic [ENT_W-1:0]  wdata, rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q  <= RST_TRIGGER;
			settle_q   <= RST_SETTLE;
			readings_q <= RST_READINGS;
			tpc_q      <= RST_TPC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRIGGER:  trigger_q  <= cfg_data[TRIG_W-1:0];
				CFG_SETTLE:   settle_q   <= cfg_data[TICK_W-1:0];
				CFG_READINGS: readings_q <= cfg_data[RDG_W-1:0];
				CFG_TPC:      tpc_q      <= cfg_data[TPC_W-1:0];
				default:      tpc_q      <= tpc_q;
			endcase
		end
	end

	assign s_tready = !full;
	assign take     = s_tvalid && s_tready;

	uer_front #(
		.WIDTH_BITS(WIDTH_BITS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.take               (take),
		.start_req          (s_tdata[0]),
		.echo_level         (s_tdata[1]),
		.trigger_ticks      (trigger_q),
		.settle_ticks       (settle_q),
		.readings_per_result(readings_q),
		.ticks_per_cm       (tpc_q),
		.ctl                (f_ctl),
		.sum                (f_sum),
		.den                (f_den)
	);

	assign wdata = {f_ctl, f_den, f_sum};

	uer_fifo #(
		.DATA_W(ENT_W)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.wdata (wdata),
		.pop   (pop),
		.rdata (rdata),
		.full  (full),
		.empty (empty)
	);

	assign b_ctl = rdata[ENT_W-1 -: CTL_W];
	assign b_den = rdata[SUM_W +: DEN_W];
	assign b_sum = rdata[SUM_W-1:0];

	uer_back #(
		.WIDTH_BITS   (WIDTH_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.ent_ctl (b_ctl),
		.ent_den (b_den),
		.ent_sum (b_sum),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

[sv/uer_front.sv]
// front end: per-tick measurement sequencer that classifies each item
module uer_front #(
	parameter int WIDTH_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic                        start_req,
	input  logic                        echo_level,
	input  logic [uer_pkg::TRIG_W-1:0]  trigger_ticks,
	input  logic [uer_pkg::TICK_W-1:0]  settle_ticks,
	input  logic [uer_pkg::RDG_W-1:0]   readings_per_result,
	input  logic [uer_pkg::TPC_W-1:0]   ticks_per_cm,
	output uer_pkg::ctl_t               ctl,
	output logic [WIDTH_BITS+2:0]       sum,
	output logic [uer_pkg::DEN_W-1:0]   den
);
	import uer_pkg::*;

	localparam int SUM_W = WIDTH_BITS + 3;

	ph_t                   phase_q, phase_d;
	logic [TICK_W-1:0]     ticks_q, ticks_d;
	logic [WIDTH_BITS-1:0] width_q, width_d;
	logic [RDG_W-1:0]      done_q, done_d;
	logic [SUM_W-1:0]      sum_q, sum_d;

	logic [TRIG_W-1:0]        trig_len;
	logic [RDG_W-1:0]         eff_n;
	logic [TPC_W-1:0]         eff_tpc;
	logic [TPC_W+RDG_W-1:0]   den_full;
	logic [TICK_W-1:0]        tick_base, tick_inc;
	logic                     trig_end, settle_more, last_rdg;
	logic                     trig, res;

	assign trig_len = (trigger_ticks == '0) ? TRIG_W'(1) : trigger_ticks;
	assign eff_n = (readings_per_result == '0) ? RDG_W'(1) :
		(readings_per_result > RDG_MAX) ? RDG_MAX : readings_per_result;
	assign eff_tpc = (ticks_per_cm == '0) ? TPC_W'(1) : ticks_per_cm;
	assign den_full = eff_tpc * eff_n;
	assign den = den_full[DEN_W-1:0];

	assign tick_base   = (phase_q == PH_TRIG) ? ticks_q : '0;
	assign tick_inc    = tick_base + TICK_W'(1);
	assign trig_end    = tick_inc >= TICK_W'(trig_len);
	assign settle_more = ticks_q < settle_ticks;
	assign last_rdg    = done_q >= eff_n;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_TRIG: begin
				phase_d = trig_end ? PH_WAIT : PH_TRIG;
			end
			PH_WAIT: begin
				if (echo_level) phase_d = PH_MEAS;
			end
			PH_MEAS: begin
				if (!echo_level) phase_d = PH_SETTLE;
			end
			PH_SETTLE: begin
				if (!settle_more) begin
					if (last_rdg) phase_d = PH_IDLE;
					else phase_d = trig_end ? PH_WAIT : PH_TRIG;
				end
			end
			default: begin
				phase_d = start_req ? (trig_end ? PH_WAIT : PH_TRIG) : PH_IDLE;
			end
		endcase
	end

	// datapath and item flags
	always_comb begin
		ticks_d = ticks_q;
		width_d = width_q;
		done_d  = done_q;
		sum_d   = sum_q;
		trig    = 1'b0;
		res     = 1'b0;
		unique case (phase_q)
			PH_TRIG: begin
				trig    = 1'b1;
				ticks_d = trig_end ? '0 : tick_inc;
			end
			PH_WAIT: begin
				if (echo_level) width_d = WIDTH_BITS'(1);
			end
			PH_MEAS: begin
				if (echo_level) begin
					if (width_q != '1) width_d = width_q + WIDTH_BITS'(1);
				end else begin
					sum_d   = sum_q + SUM_W'(width_q);
					done_d  = done_q + RDG_W'(1);
					ticks_d = '0;
				end
			end
			PH_SETTLE: begin
				if (settle_more) begin
					ticks_d = ticks_q + TICK_W'(1);
				end else if (last_rdg) begin
					res     = 1'b1;
					ticks_d = '0;
				end else begin
					width_d = '0;
					trig    = 1'b1;
					ticks_d = trig_end ? '0 : tick_inc;
				end
			end
			default: begin
				if (start_req) begin
					sum_d   = '0;
					done_d  = '0;
					width_d = '0;
					trig    = 1'b1;
					ticks_d = trig_end ? '0 : tick_inc;
				end
			end
		endcase
	end

	assign ctl.trig = trig;
	assign ctl.busy = (phase_d != PH_IDLE);
	assign ctl.res  = res;
	assign sum      = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			width_q <= '0;
			done_q  <= '0;
			sum_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			width_q <= width_d;
			done_q  <= done_d;
			sum_q   <= sum_d;
		end
	end

endmodule

[sv/uer_fifo.sv]
// two-entry queue between the front and back ends
`include "ultrasonic_echo_ranger_assert.svh"

module uer_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              full,
	output logic              empty
);
	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;

	assign rdata = mem_q[rd_ptr_q];
	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`UER_NEVER(a_no_push_full, clk, arst_n, push && full)
	`UER_NEVER(a_no_pop_empty, clk, arst_n, pop && empty)
	`UER_ASSERT(a_count_track, clk, arst_n,
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
endmodule

[sv/uer_back.sv]
// back end: restoring divider for the distance and the output register
module uer_back #(
	parameter int WIDTH_BITS    = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            empty,
	input  uer_pkg::ctl_t                   ent_ctl,
	input  logic [uer_pkg::DEN_W-1:0]       ent_den,
	input  logic [WIDTH_BITS+2:0]           ent_sum,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [uer_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import uer_pkg::*;

	localparam int SUM_W = WIDTH_BITS + 3;
	localparam int NUM_W = SUM_W + FRACTION_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int QX_W  = (NUM_W > DIST_W) ? NUM_W : DIST_W;

	bk_t               state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [DEN_W-1:0]  rem_q, den_q;
	logic [NUM_W-1:0]  quo_q;
	ctl_t              ctl_q;

	logic              out_valid_q;
	ctl_t              out_ctl_q;
	logic [DIST_W-1:0] out_dist_q;

	logic              out_free, load_div, out_load, step_last;
	logic [DEN_W:0]    trial;
	logic              ge;
	logic [QX_W-1:0]   q_ext;
	logic [DIST_W-1:0] q_sat;
	ctl_t              new_ctl;
	logic [DIST_W-1:0] new_dist;

	assign out_free  = !out_valid_q || m_tready;
	assign trial     = {rem_q, quo_q[NUM_W-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign step_last = (cnt_q == CNT_W'(NUM_W - 1));
	assign q_ext     = QX_W'(quo_q);
	assign q_sat     = (|(q_ext >> DIST_W)) ? '1 : q_ext[DIST_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_LOAD: begin
				if (!empty && ent_ctl.res) state_d = BK_DIV;
			end
			BK_DIV: begin
				if (step_last) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) state_d = BK_LOAD;
			end
			default: begin
				state_d = BK_LOAD;
			end
		endcase
	end

	// control outputs
	always_comb begin
		pop      = 1'b0;
		load_div = 1'b0;
		out_load = 1'b0;
		new_ctl  = ent_ctl;
		new_dist = '0;
		unique case (state_q)
			BK_LOAD: begin
				if (!empty && ent_ctl.res) begin
					pop      = 1'b1;
					load_div = 1'b1;
				end else if (!empty && out_free) begin
					pop      = 1'b1;
					out_load = 1'b1;
				end
			end
			BK_DONE: begin
				out_load = out_free;
				new_ctl  = ctl_q;
				new_dist = q_sat;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= NUM_W'(ent_sum) << FRACTION_BITS;
			den_q <= ent_den;
			ctl_q <= ent_ctl;
		end else if (state_q == BK_DIV) begin
			cnt_q <= cnt_q + CNT_W'(1);
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
		if (out_load) begin
			out_ctl_q  <= new_ctl;
			out_dist_q <= new_dist;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({out_dist_q, out_ctl_q.res, out_ctl_q.busy,
		out_ctl_q.trig});

endmodule
